// ----- rtl/mcg_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mcg_pkg: shared types, codes and microcode for the multiset combination core
// Holds the transfer payload types, action and status codes, the micro-op
// and branch condition encodings, and the microcode ROM.
// ---------------------------------------------------------------------------
package mcg_pkg;

    localparam int MAX_VALUES_DEF = 8;
    localparam int VALUE_BITS_DEF = 16;

    localparam int OUT_SLOTS  = 8;
    localparam int SLOT_W     = 3;
    localparam int SLOT_CNT_W = 4;
    localparam int K_W        = 4;
    localparam int ELEM_W     = 16;
    localparam int IN_VAL_W   = 16;
    localparam int UPC_W      = 5;

    typedef logic [UPC_W-1:0] upc_t;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_LOAD  = 2'd1,
        ACT_NEXT  = 2'd2,
        ACT_SPARE = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_CLEARED   = 3'd0,
        ST_LOADED    = 3'd1,
        ST_COMBO     = 3'd2,
        ST_EXHAUSTED = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    typedef struct packed {
        logic [1:0]          action;
        logic [IN_VAL_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [K_W-1:0]    tuple_length;
        logic [ELEM_W-1:0] elem0;
        logic [ELEM_W-1:0] elem1;
        logic [ELEM_W-1:0] elem2;
        logic [ELEM_W-1:0] elem3;
        logic [ELEM_W-1:0] elem4;
        logic [ELEM_W-1:0] elem5;
        logic [ELEM_W-1:0] elem6;
        logic [ELEM_W-1:0] elem7;
    } out_item_t;

    typedef enum logic [4:0] {
        UOP_NOP,
        UOP_CLEAR,
        UOP_LD_INIT,
        UOP_RD_POSM1,
        UOP_LD_SHIFT,
        UOP_LD_PUT,
        UOP_ST_FULL,
        UOP_START,
        UOP_INIT_IDX,
        UOP_P_LOAD,
        UOP_P_DEC,
        UOP_RD_CUR,
        UOP_CAP_CUR,
        UOP_RD_J,
        UOP_J_INC,
        UOP_SET_IDX,
        UOP_G_INIT,
        UOP_RD_IDX,
        UOP_G_CAP,
        UOP_SET_EXH,
        UOP_ST_EXH,
        UOP_EMIT
    } uop_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_FULL,
        C_POS_ZERO,
        C_RD_LE_V,
        C_EXH,
        C_STARTED,
        C_FIRST_BAD,
        C_P_ZERO,
        C_J_GE_N,
        C_RD_NE_CV,
        C_FIT_BAD,
        C_I_GE_K,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        uop_t  op;
        cond_t cond;
        upc_t  tgt;
    } ucode_t;

    // sequencer to datapath
    typedef struct packed {
        logic start;
        logic emit;
        uop_t op;
    } seq_ctl_t;

    // datapath to sequencer
    typedef struct packed {
        logic full;
        logic pos_zero;
        logic rd_le_v;
        logic exh;
        logic started;
        logic first_bad;
        logic p_zero;
        logic j_ge_n;
        logic rd_ne_cv;
        logic fit_bad;
        logic i_ge_k;
    } dp_flags_t;

    // microcode addresses
    localparam upc_t U_CLR      = 5'd0;
    localparam upc_t U_LD       = 5'd1;
    localparam upc_t U_LD_TEST  = 5'd2;
    localparam upc_t U_LD_RD    = 5'd3;
    localparam upc_t U_LD_CMP   = 5'd4;
    localparam upc_t U_LD_SHIFT = 5'd5;
    localparam upc_t U_LD_PUT   = 5'd6;
    localparam upc_t U_LD_FULL  = 5'd7;
    localparam upc_t U_NX       = 5'd8;
    localparam upc_t U_NX_ST    = 5'd9;
    localparam upc_t U_NX_START = 5'd10;
    localparam upc_t U_NX_INIT  = 5'd11;
    localparam upc_t U_ADV      = 5'd12;
    localparam upc_t U_PLOOP    = 5'd13;
    localparam upc_t U_PDEC     = 5'd14;
    localparam upc_t U_RDCUR    = 5'd15;
    localparam upc_t U_CAPCUR   = 5'd16;
    localparam upc_t U_SCAN     = 5'd17;
    localparam upc_t U_RDJ      = 5'd18;
    localparam upc_t U_CMPJ     = 5'd19;
    localparam upc_t U_JINC     = 5'd20;
    localparam upc_t U_TEST     = 5'd21;
    localparam upc_t U_SETIDX   = 5'd22;
    localparam upc_t U_GINIT    = 5'd23;
    localparam upc_t U_GLOOP    = 5'd24;
    localparam upc_t U_RDIDX    = 5'd25;
    localparam upc_t U_GCAP     = 5'd26;
    localparam upc_t U_EXHSET   = 5'd27;
    localparam upc_t U_EXH      = 5'd28;
    localparam upc_t U_EMIT     = 5'd29;

    function automatic ucode_t ucode_rom(input upc_t a);
        ucode_t w;
        w = '{op: UOP_EMIT, cond: C_OUT_BUSY, tgt: U_EMIT};
        unique case (a)
            // clear
            U_CLR:      w = '{op: UOP_CLEAR,    cond: C_ALWAYS,    tgt: U_EMIT};
            // load: insertion, shifting larger entries up one slot
            U_LD:       w = '{op: UOP_LD_INIT,  cond: C_FULL,      tgt: U_LD_FULL};
            U_LD_TEST:  w = '{op: UOP_NOP,      cond: C_POS_ZERO,  tgt: U_LD_PUT};
            U_LD_RD:    w = '{op: UOP_RD_POSM1, cond: C_NEVER,     tgt: U_CLR};
            U_LD_CMP:   w = '{op: UOP_NOP,      cond: C_RD_LE_V,   tgt: U_LD_PUT};
            U_LD_SHIFT: w = '{op: UOP_LD_SHIFT, cond: C_ALWAYS,    tgt: U_LD_TEST};
            U_LD_PUT:   w = '{op: UOP_LD_PUT,   cond: C_ALWAYS,    tgt: U_EMIT};
            U_LD_FULL:  w = '{op: UOP_ST_FULL,  cond: C_ALWAYS,    tgt: U_EMIT};
            // next combination
            U_NX:       w = '{op: UOP_NOP,      cond: C_EXH,       tgt: U_EXH};
            U_NX_ST:    w = '{op: UOP_NOP,      cond: C_STARTED,   tgt: U_ADV};
            U_NX_START: w = '{op: UOP_START,    cond: C_FIRST_BAD, tgt: U_EXHSET};
            U_NX_INIT:  w = '{op: UOP_INIT_IDX, cond: C_ALWAYS,    tgt: U_GINIT};
            U_ADV:      w = '{op: UOP_P_LOAD,   cond: C_NEVER,     tgt: U_CLR};
            U_PLOOP:    w = '{op: UOP_NOP,      cond: C_P_ZERO,    tgt: U_EXHSET};
            U_PDEC:     w = '{op: UOP_P_DEC,    cond: C_NEVER,     tgt: U_CLR};
            U_RDCUR:    w = '{op: UOP_RD_CUR,   cond: C_NEVER,     tgt: U_CLR};
            U_CAPCUR:   w = '{op: UOP_CAP_CUR,  cond: C_NEVER,     tgt: U_CLR};
            U_SCAN:     w = '{op: UOP_NOP,      cond: C_J_GE_N,    tgt: U_TEST};
            U_RDJ:      w = '{op: UOP_RD_J,     cond: C_NEVER,     tgt: U_CLR};
            U_CMPJ:     w = '{op: UOP_NOP,      cond: C_RD_NE_CV,  tgt: U_TEST};
            U_JINC:     w = '{op: UOP_J_INC,    cond: C_ALWAYS,    tgt: U_SCAN};
            U_TEST:     w = '{op: UOP_NOP,      cond: C_FIT_BAD,   tgt: U_PLOOP};
            U_SETIDX:   w = '{op: UOP_SET_IDX,  cond: C_NEVER,     tgt: U_CLR};
            // gather the chosen values into the result
            U_GINIT:    w = '{op: UOP_G_INIT,   cond: C_NEVER,     tgt: U_CLR};
            U_GLOOP:    w = '{op: UOP_NOP,      cond: C_I_GE_K,    tgt: U_EMIT};
            U_RDIDX:    w = '{op: UOP_RD_IDX,   cond: C_NEVER,     tgt: U_CLR};
            U_GCAP:     w = '{op: UOP_G_CAP,    cond: C_ALWAYS,    tgt: U_GLOOP};
            U_EXHSET:   w = '{op: UOP_SET_EXH,  cond: C_NEVER,     tgt: U_CLR};
            U_EXH:      w = '{op: UOP_ST_EXH,   cond: C_ALWAYS,    tgt: U_EMIT};
            U_EMIT:     w = '{op: UOP_EMIT,     cond: C_OUT_BUSY,  tgt: U_EMIT};
            default:    w = '{op: UOP_EMIT,     cond: C_OUT_BUSY,  tgt: U_EMIT};
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/mcg_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mcg_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered and holds
// while no read is issued.
// ---------------------------------------------------------------------------
module mcg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/mcg_useq.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mcg_useq: microcode sequencer
// Dispatches each accepted request to its microroutine, steps the program
// counter through the ROM and takes conditional jumps on datapath flags.
// ---------------------------------------------------------------------------
module mcg_useq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    input  logic [1:0]           action,
    input  mcg_pkg::dp_flags_t   flags,
    input  logic                 out_busy,
    output logic                 req_ready,
    output mcg_pkg::seq_ctl_t    ctl
);
    import mcg_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } state_t;

    state_t state_reg;
    state_t state_next;
    upc_t   upc_reg;
    upc_t   upc_next;
    ucode_t word;
    upc_t   entry;
    logic   take;
    logic   start;
    logic   emit;

    assign word  = ucode_rom(upc_reg);
    assign start = (state_reg == S_IDLE) && req_valid;
    assign emit  = (state_reg == S_RUN) && (word.op == UOP_EMIT) && !out_busy;

    always_comb
    begin
        unique case (action_t'(action))
            ACT_CLEAR: entry = U_CLR;
            ACT_LOAD:  entry = U_LD;
            default:   entry = U_NX;
        endcase
    end

    always_comb
    begin
        unique case (word.cond)
            C_NEVER:     take = 1'b0;
            C_ALWAYS:    take = 1'b1;
            C_FULL:      take = flags.full;
            C_POS_ZERO:  take = flags.pos_zero;
            C_RD_LE_V:   take = flags.rd_le_v;
            C_EXH:       take = flags.exh;
            C_STARTED:   take = flags.started;
            C_FIRST_BAD: take = flags.first_bad;
            C_P_ZERO:    take = flags.p_zero;
            C_J_GE_N:    take = flags.j_ge_n;
            C_RD_NE_CV:  take = flags.rd_ne_cv;
            C_FIT_BAD:   take = flags.fit_bad;
            C_I_GE_K:    take = flags.i_ge_k;
            C_OUT_BUSY:  take = out_busy;
            default:     take = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        upc_next   = upc_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_RUN;
                    upc_next   = entry;
                end
            end
            S_RUN:
            begin
                if (emit)
                begin
                    state_next = S_IDLE;
                end
                else if (take)
                begin
                    upc_next = word.tgt;
                end
                else
                begin
                    upc_next = upc_reg + upc_t'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            upc_reg   <= U_CLR;
        end
        else
        begin
            state_reg <= state_next;
            upc_reg   <= upc_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign ctl.start = start;
    assign ctl.emit  = emit;
    assign ctl.op    = (state_reg == S_RUN) ? word.op : UOP_NOP;

endmodule

// ----- rtl/mcg_dpath.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mcg_dpath: datapath for the combination core
// Sorted value store, chosen-index registers, scan counters and the
// result registers, all driven by one micro-op per cycle.
// ---------------------------------------------------------------------------
module mcg_dpath #(
    parameter int MAX_VALUES = mcg_pkg::MAX_VALUES_DEF,
    parameter int VALUE_BITS = mcg_pkg::VALUE_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  mcg_pkg::seq_ctl_t          ctl,
    input  mcg_pkg::in_item_t          req,
    input  logic                       cfg_we,
    input  logic [mcg_pkg::K_W-1:0]    cfg_wdata,
    output mcg_pkg::dp_flags_t         flags,
    output mcg_pkg::out_item_t         result
);
    import mcg_pkg::*;

    localparam int CNT_W = $clog2(MAX_VALUES + 1);
    localparam int IDX_W = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
    localparam int SUM_W = CNT_W + K_W;
    localparam int EXT_W = VALUE_BITS + ELEM_W + IN_VAL_W;

    // control state
    logic [CNT_W-1:0]      n_reg, n_next;
    logic                  started_reg, started_next;
    logic                  exh_reg, exh_next;
    logic [K_W-1:0]        k_reg, k_next;
    logic [IDX_W-1:0]      idx_reg [OUT_SLOTS];
    logic [IDX_W-1:0]      idx_next [OUT_SLOTS];

    // working registers
    logic [CNT_W-1:0]      pos_reg, pos_next;
    logic [CNT_W-1:0]      j_reg, j_next;
    logic [SLOT_CNT_W-1:0] p_reg, p_next;
    logic [SLOT_CNT_W-1:0] i_reg, i_next;
    logic [VALUE_BITS-1:0] cv_reg, cv_next;
    logic [VALUE_BITS-1:0] v_reg, v_next;
    status_t               st_reg, st_next;
    logic [K_W-1:0]        len_reg, len_next;
    logic [ELEM_W-1:0]     elem_reg [OUT_SLOTS];
    logic [ELEM_W-1:0]     elem_next [OUT_SLOTS];

    // store port
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [VALUE_BITS-1:0] ram_wdata;
    logic                  ram_re;
    logic [IDX_W-1:0]      ram_raddr;
    logic [VALUE_BITS-1:0] rdata;

    logic [SLOT_CNT_W-1:0] idx_sel;
    logic [IDX_W-1:0]      idx_rd;
    logic [CNT_W-1:0]      pos_m1;
    logic [EXT_W-1:0]      v_ext;
    logic [EXT_W-1:0]      r_ext;
    logic [SUM_W-1:0]      fit_sum;

    mcg_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_VALUES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rdata)
    );

    assign idx_sel = (ctl.op == UOP_RD_IDX) ? i_reg : p_reg;
    assign idx_rd  = idx_reg[idx_sel[SLOT_W-1:0]];
    assign pos_m1  = pos_reg - CNT_W'(1);
    assign v_ext   = EXT_W'(req.value);
    assign r_ext   = EXT_W'(rdata);
    // last index the tail would need if position p took index j
    assign fit_sum = SUM_W'(j_reg) + SUM_W'(k_reg) - SUM_W'(p_reg) - SUM_W'(1);

    assign flags.full      = (n_reg == CNT_W'(MAX_VALUES));
    assign flags.pos_zero  = (pos_reg == '0);
    assign flags.rd_le_v   = (rdata <= v_reg);
    assign flags.exh       = exh_reg;
    assign flags.started   = started_reg;
    assign flags.first_bad = (SUM_W'(k_reg) > SUM_W'(n_reg))
                          || (SUM_W'(k_reg) > SUM_W'(OUT_SLOTS));
    assign flags.p_zero    = (p_reg == '0);
    assign flags.j_ge_n    = (j_reg >= n_reg);
    assign flags.rd_ne_cv  = (rdata != cv_reg);
    assign flags.fit_bad   = (fit_sum >= SUM_W'(n_reg));
    assign flags.i_ge_k    = (SUM_W'(i_reg) >= SUM_W'(k_reg));

    always_comb
    begin
        n_next       = n_reg;
        started_next = started_reg;
        exh_next     = exh_reg;
        k_next       = k_reg;
        idx_next     = idx_reg;
        pos_next     = pos_reg;
        j_next       = j_reg;
        p_next       = p_reg;
        i_next       = i_reg;
        cv_next      = cv_reg;
        v_next       = v_reg;
        st_next      = st_reg;
        len_next     = len_reg;
        elem_next    = elem_reg;
        ram_we       = 1'b0;
        ram_waddr    = pos_reg[IDX_W-1:0];
        ram_wdata    = v_reg;
        ram_re       = 1'b0;
        ram_raddr    = idx_rd;

        if (ctl.start)
        begin
            v_next   = v_ext[VALUE_BITS-1:0];
            len_next = '0;
            for (int q = 0; q < OUT_SLOTS; q++)
            begin
                elem_next[q] = '0;
            end
        end

        // a new subset size restarts the enumeration
        if (cfg_we)
        begin
            k_next       = cfg_wdata;
            started_next = 1'b0;
            exh_next     = 1'b0;
        end

        unique case (ctl.op)
            UOP_CLEAR:
            begin
                n_next       = '0;
                started_next = 1'b0;
                exh_next     = 1'b0;
                st_next      = ST_CLEARED;
            end
            UOP_LD_INIT:
            begin
                pos_next = n_reg;
            end
            UOP_RD_POSM1:
            begin
                ram_re    = 1'b1;
                ram_raddr = pos_m1[IDX_W-1:0];
            end
            UOP_LD_SHIFT:
            begin
                ram_we    = 1'b1;
                ram_wdata = rdata;
                pos_next  = pos_m1;
            end
            UOP_LD_PUT:
            begin
                ram_we       = 1'b1;
                n_next       = n_reg + CNT_W'(1);
                started_next = 1'b0;
                exh_next     = 1'b0;
                st_next      = ST_LOADED;
            end
            UOP_ST_FULL:
            begin
                st_next = ST_FULL;
            end
            UOP_START:
            begin
                started_next = 1'b1;
            end
            UOP_INIT_IDX:
            begin
                for (int q = 0; q < OUT_SLOTS; q++)
                begin
                    idx_next[q] = IDX_W'(q);
                end
            end
            UOP_P_LOAD:
            begin
                p_next = SLOT_CNT_W'(k_reg);
            end
            UOP_P_DEC:
            begin
                p_next = p_reg - SLOT_CNT_W'(1);
            end
            UOP_RD_CUR:
            begin
                ram_re = 1'b1;
                j_next = CNT_W'(idx_rd) + CNT_W'(1);
            end
            UOP_CAP_CUR:
            begin
                cv_next = rdata;
            end
            UOP_RD_J:
            begin
                ram_re    = 1'b1;
                ram_raddr = j_reg[IDX_W-1:0];
            end
            UOP_J_INC:
            begin
                j_next = j_reg + CNT_W'(1);
            end
            UOP_SET_IDX:
            begin
                // position p takes j, the tail follows on consecutive indices
                for (int q = 0; q < OUT_SLOTS; q++)
                begin
                    if (SLOT_CNT_W'(q) >= p_reg)
                    begin
                        idx_next[q] = IDX_W'(SUM_W'(j_reg) + SUM_W'(q) - SUM_W'(p_reg));
                    end
                end
            end
            UOP_G_INIT:
            begin
                i_next   = '0;
                st_next  = ST_COMBO;
                len_next = k_reg;
            end
            UOP_RD_IDX:
            begin
                ram_re = 1'b1;
            end
            UOP_G_CAP:
            begin
                elem_next[i_reg[SLOT_W-1:0]] = r_ext[ELEM_W-1:0];
                i_next = i_reg + SLOT_CNT_W'(1);
            end
            UOP_SET_EXH:
            begin
                exh_next = 1'b1;
            end
            UOP_ST_EXH:
            begin
                st_next = ST_EXHAUSTED;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg       <= '0;
            started_reg <= 1'b0;
            exh_reg     <= 1'b0;
            k_reg       <= K_W'(1);
            for (int q = 0; q < OUT_SLOTS; q++)
            begin
                idx_reg[q] <= '0;
            end
        end
        else
        begin
            n_reg       <= n_next;
            started_reg <= started_next;
            exh_reg     <= exh_next;
            k_reg       <= k_next;
            idx_reg     <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        j_reg    <= j_next;
        p_reg    <= p_next;
        i_reg    <= i_next;
        cv_reg   <= cv_next;
        v_reg    <= v_next;
        st_reg   <= st_next;
        len_reg  <= len_next;
        elem_reg <= elem_next;
    end

    assign result.status       = st_reg;
    assign result.tuple_length = len_reg;
    assign result.elem0        = elem_reg[0];
    assign result.elem1        = elem_reg[1];
    assign result.elem2        = elem_reg[2];
    assign result.elem3        = elem_reg[3];
    assign result.elem4        = elem_reg[4];
    assign result.elem5        = elem_reg[5];
    assign result.elem6        = elem_reg[6];
    assign result.elem7        = elem_reg[7];

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= CNT_W'(MAX_VALUES))
        else $error("value count beyond store depth");

    a_exh_started: assert property (@(posedge clk) disable iff (!rst_n)
        exh_reg |-> started_reg)
        else $error("exhausted without a started enumeration");

    a_gather_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.op == UOP_G_CAP) |-> (SUM_W'(i_reg) < SUM_W'(k_reg)))
        else $error("gather past subset size");

    a_setidx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.op == UOP_SET_IDX) |-> (SUM_W'(p_reg) < SUM_W'(k_reg)))
        else $error("index update at position outside the tuple");

endmodule

// ----- rtl/multiset_combination_generator_core.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// multiset_combination_generator_core: distinct multiset combinations
// Sorted value store with a microcoded enumerator of distinct, nondecreasing
// subset_size tuples in lexicographic order.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready/req_data) carries one action per
//   transfer: clear, load value, or next combination. Each accepted request
//   produces exactly one response transfer on rsp_valid/rsp_ready/rsp_data.
//   cfg_we/cfg_wdata write subset_size; write it only while idle. Any write
//   restarts the enumeration.
// Flow:
//   One request at a time; req_ready is high while the sequencer is idle,
//   so the next request can transfer in the same cycle that rsp_valid rises.
//   Load into a full store only reports full; otherwise each stored value
//   above the new one moves up a slot. Next tries positions from the last
//   down, skipping stored values equal to the current one, and reports
//   exhausted once no position is left or when no tuple fits at all.
//   The value store has a single read port with registered read data, so
//   every store access is a read step followed by a step that uses it.
// Reset and stall:
//   Reset empties the store, sets subset_size to 1 and clears the
//   enumeration. The response register holds a finished result while the
//   receiver stalls; the next request is still taken and worked on, and
//   its result waits in the sequencer until the register frees.
// ---------------------------------------------------------------------------
module multiset_combination_generator_core #(
    parameter int MAX_VALUES = mcg_pkg::MAX_VALUES_DEF,
    parameter int VALUE_BITS = mcg_pkg::VALUE_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_ready,
    input  mcg_pkg::in_item_t       req_data,
    output logic                    rsp_valid,
    input  logic                    rsp_ready,
    output mcg_pkg::out_item_t      rsp_data,
    input  logic                    cfg_we,
    input  logic [mcg_pkg::K_W-1:0] cfg_wdata
);
    import mcg_pkg::*;

    seq_ctl_t  ctl;
    dp_flags_t flags;
    out_item_t result;
    logic      out_busy;
    logic      rsp_valid_reg;
    out_item_t rsp_data_reg;

    assign out_busy = rsp_valid_reg && !rsp_ready;

    mcg_useq u_useq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .action    (req_data.action),
        .flags     (flags),
        .out_busy  (out_busy),
        .req_ready (req_ready),
        .ctl       (ctl)
    );

    mcg_dpath #(
        .MAX_VALUES (MAX_VALUES),
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .req       (req_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .flags     (flags),
        .result    (result)
    );

    // response register: load on emit, drop after the transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (ctl.emit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            rsp_data_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request taken while a request is in progress");

    a_rsp_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(ctl.emit))
        else $error("response raised without an emit step");

endmodule
